[sv/cstr_pkg.sv]
// cstr_pkg: shared widths, constants, types and tables for the cubic stiffness rotation core
// no dependencies; imported by every module of the block

package cstr_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int WFRAC             = 30;
  localparam int SCALE_SH          = WFRAC - FRAC_BITS;
  localparam int CORDIC_STAGES_DEF = 18;

  localparam int ANG_W = 19;
  localparam int ZW    = 35;
  localparam int WW    = 34;
  localparam int SW    = 40;
  localparam int KW    = 32;
  localparam int VW    = 40;

  localparam int FIFO_DEPTH = 2;

  localparam logic [4:0] LAST_T = 5'd20;

  localparam logic [1:0] REG_C11 = 2'd0;
  localparam logic [1:0] REG_C12 = 2'd1;
  localparam logic [1:0] REG_C44 = 2'd2;

  localparam logic signed [ZW-1:0] PI_W      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_W = 35'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_W  = 35'sd6746518852;
  localparam logic signed [WW-1:0] GAIN_W    = 34'sd652032874;

  localparam logic signed [2*WW-1:0] MUL_RND = (2*WW)'(64'sd1 <<< (WFRAC - 1));

  // rotation matrix, entry row*3+col
  typedef logic [8:0][WW-1:0] mat_t;

  typedef struct packed {
    logic signed [KW-1:0] k11;
    logic signed [KW-1:0] k12;
    logic signed [KW-1:0] k44;
  } coef_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [1:0] {
    CLS_11 = 2'd0,
    CLS_12 = 2'd1,
    CLS_44 = 2'd2
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [1:0] c0;
    logic [1:0] c1;
    logic [1:0] c2;
    logic [1:0] c3;
  } term_t;

  // product of two 30-bit-fraction values, rounded half up
  function automatic logic signed [WW-1:0] mulw(input logic signed [WW-1:0] a,
                                                 input logic signed [WW-1:0] b);
    logic signed [2*WW-1:0] prod;
    prod = a * b;
    prod = prod + MUL_RND;
    return prod[WFRAC+WW-1:WFRAC];
  endfunction

  function automatic logic signed [ZW-1:0] atan_w(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 35'sd843314857;
      5'd1:  r = 35'sd497837829;
      5'd2:  r = 35'sd263043837;
      5'd3:  r = 35'sd133525159;
      5'd4:  r = 35'sd67021687;
      5'd5:  r = 35'sd33543516;
      5'd6:  r = 35'sd16775851;
      5'd7:  r = 35'sd8388437;
      5'd8:  r = 35'sd4194283;
      5'd9:  r = 35'sd2097149;
      5'd10: r = 35'sd1048576;
      5'd11: r = 35'sd524288;
      5'd12: r = 35'sd262144;
      5'd13: r = 35'sd131072;
      5'd14: r = 35'sd65536;
      5'd15: r = 35'sd32768;
      5'd16: r = 35'sd16384;
      5'd17: r = 35'sd8192;
      5'd18: r = 35'sd4096;
      5'd19: r = 35'sd2048;
      5'd20: r = 35'sd1024;
      5'd21: r = 35'sd512;
      5'd22: r = 35'sd256;
      5'd23: r = 35'sd128;
      5'd24: r = 35'sd64;
      5'd25: r = 35'sd32;
      5'd26: r = 35'sd16;
      5'd27: r = 35'sd8;
      5'd28: r = 35'sd4;
      5'd29: r = 35'sd2;
      5'd30: r = 35'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // first and second tensor index of a voigt index
  function automatic logic [1:0] voigt_a(input logic [2:0] n);
    logic [1:0] r;
    case (n)
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] voigt_b(input logic [2:0] n);
    logic [1:0] r;
    case (n)
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // ordered pairs p != q, as {p, q}
  function automatic logic [3:0] pair_pq(input logic [2:0] n);
    logic [3:0] r;
    case (n)
      3'd0:    r = {2'd0, 2'd1};
      3'd1:    r = {2'd0, 2'd2};
      3'd2:    r = {2'd1, 2'd0};
      3'd3:    r = {2'd1, 2'd2};
      3'd4:    r = {2'd2, 2'd0};
      3'd5:    r = {2'd2, 2'd1};
      default: r = {2'd0, 2'd1};
    endcase
    return r;
  endfunction

  // term t of a component: class and the column of each of the four factors
  function automatic term_t term_of(input logic [4:0] t);
    term_t      r;
    logic [3:0] pq;
    logic [1:0] p;
    logic [1:0] q;
    pq = '0;
    if (t < 5'd3) begin
      r = '{cls: CLS_11, c0: t[1:0], c1: t[1:0], c2: t[1:0], c3: t[1:0]};
    end else if (t < 5'd9) begin
      pq = pair_pq(3'(t - 5'd3));
      p  = pq[3:2];
      q  = pq[1:0];
      r  = '{cls: CLS_12, c0: p, c1: p, c2: q, c3: q};
    end else if (t < 5'd15) begin
      pq = pair_pq(3'(t - 5'd9));
      p  = pq[3:2];
      q  = pq[1:0];
      r  = '{cls: CLS_44, c0: p, c1: q, c2: p, c3: q};
    end else begin
      pq = pair_pq(3'(t - 5'd15));
      p  = pq[3:2];
      q  = pq[1:0];
      r  = '{cls: CLS_44, c0: p, c1: q, c2: q, c3: p};
    end
    return r;
  endfunction

endpackage

[sv/cstr_front.sv]
// cstr_front: input slot, angle reduction, three iterative cordic lanes and the
// sequenced products that form the rotation matrix; depends on cstr_pkg

module cstr_front import cstr_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [ANG_W-1:0] angle_first_i,
  input  logic signed [ANG_W-1:0] angle_second_i,
  input  logic signed [ANG_W-1:0] angle_third_i,
  output logic                    push_o,
  output mat_t                    push_mat_o,
  input  fifo_stat_t              fifo_stat_i
);

  localparam int         NSTG      = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam logic [4:0] ITER_LAST = 5'(NSTG - 1);
  localparam int         NPROD     = 14;
  localparam logic [3:0] PROD_LAST = 4'(NPROD - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROT  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_PUSH = 4'b1000
  } state_e;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 flip;
  } red_t;

  // |angle| << 14 stays below 2*pi, so a single remainder step brings it into [-pi, pi]
  function automatic red_t reduce(input logic signed [ANG_W-1:0] a);
    red_t r;
    r.z    = ZW'(a) <<< SCALE_SH;
    r.flip = 1'b0;
    if (r.z > PI_W) begin
      r.z = r.z - TWO_PI_W;
    end else if (r.z < -PI_W) begin
      r.z = r.z + TWO_PI_W;
    end
    if (r.z > HALF_PI_W) begin
      r.z    = r.z - PI_W;
      r.flip = 1'b1;
    end else if (r.z < -HALF_PI_W) begin
      r.z    = r.z + PI_W;
      r.flip = 1'b1;
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic   hold_vld_q, hold_vld_d;
  logic   [4:0] iter_q;
  logic   [3:0] k_q;

  logic signed [ANG_W-1:0] ang_q [3];
  logic signed [WW-1:0]    x_q [3];
  logic signed [WW-1:0]    y_q [3];
  logic signed [ZW-1:0]    z_q [3];
  logic                    flip_q [3];
  logic signed [WW-1:0]    p_q [NPROD];

  logic signed [WW-1:0] xs [3];
  logic signed [WW-1:0] ys [3];
  logic signed [WW-1:0] xn [3];
  logic signed [WW-1:0] yn [3];
  logic signed [ZW-1:0] zn [3];
  logic signed [ZW-1:0] at;
  red_t                 red [3];

  logic signed [WW-1:0] opa, opb, prod;
  logic accept, load, rot_last, mul_last;

  assign in_stall_o = hold_vld_q;
  assign accept     = in_valid_i && !hold_vld_q;
  assign load       = (state_q == ST_IDLE) && hold_vld_q;
  assign rot_last   = (state_q == ST_ROT) && (iter_q == ITER_LAST);
  assign mul_last   = (state_q == ST_MUL) && (k_q == PROD_LAST);
  assign push_o     = (state_q == ST_PUSH) && !fifo_stat_i.full;
  assign at         = atan_w(iter_q);

  always_comb begin
    hold_vld_d = hold_vld_q;
    if (accept) begin
      hold_vld_d = 1'b1;
    end else if (load) begin
      hold_vld_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (load) state_d = ST_ROT;
      ST_ROT:  if (rot_last) state_d = ST_MUL;
      ST_MUL:  if (mul_last) state_d = ST_PUSH;
      ST_PUSH: if (push_o) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      red[l] = reduce(ang_q[l]);
      xs[l]  = x_q[l] >>> iter_q;
      ys[l]  = y_q[l] >>> iter_q;
      if (z_q[l] >= 0) begin
        xn[l] = x_q[l] - ys[l];
        yn[l] = y_q[l] + xs[l];
        zn[l] = z_q[l] - at;
      end else begin
        xn[l] = x_q[l] + ys[l];
        yn[l] = y_q[l] - xs[l];
        zn[l] = z_q[l] + at;
      end
    end
  end

  // lane 0 phi, lane 1 theta, lane 2 psi; x holds cosine, y sine
  always_comb begin
    case (k_q)
      4'd0:    begin opa = x_q[0]; opb = x_q[1]; end
      4'd1:    begin opa = y_q[0]; opb = x_q[1]; end
      4'd2:    begin opa = y_q[1]; opb = x_q[2]; end
      4'd3:    begin opa = y_q[1]; opb = y_q[2]; end
      4'd4:    begin opa = x_q[0]; opb = y_q[1]; end
      4'd5:    begin opa = p_q[0]; opb = x_q[2]; end
      4'd6:    begin opa = y_q[0]; opb = y_q[2]; end
      4'd7:    begin opa = y_q[0]; opb = x_q[2]; end
      4'd8:    begin opa = p_q[0]; opb = y_q[2]; end
      4'd9:    begin opa = y_q[0]; opb = y_q[1]; end
      4'd10:   begin opa = x_q[0]; opb = y_q[2]; end
      4'd11:   begin opa = p_q[1]; opb = x_q[2]; end
      4'd12:   begin opa = x_q[0]; opb = x_q[2]; end
      4'd13:   begin opa = p_q[1]; opb = y_q[2]; end
      default: begin opa = '0; opb = '0; end
    endcase
    prod = mulw(opa, opb);
  end

  always_comb begin
    push_mat_o[0] = x_q[1];
    push_mat_o[1] = -p_q[2];
    push_mat_o[2] = p_q[3];
    push_mat_o[3] = p_q[4];
    push_mat_o[4] = p_q[5] - p_q[6];
    push_mat_o[5] = -p_q[7] - p_q[8];
    push_mat_o[6] = p_q[9];
    push_mat_o[7] = p_q[10] + p_q[11];
    push_mat_o[8] = p_q[12] - p_q[13];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      hold_vld_q <= 1'b0;
      iter_q     <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      hold_vld_q <= hold_vld_d;
      if (load) begin
        iter_q <= '0;
      end else if (state_q == ST_ROT) begin
        iter_q <= iter_q + 5'd1;
      end
      if (rot_last) begin
        k_q <= '0;
      end else if (state_q == ST_MUL) begin
        k_q <= k_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ang_q[0] <= angle_first_i;
      ang_q[1] <= angle_second_i;
      ang_q[2] <= angle_third_i;
    end
    for (int l = 0; l < 3; l++) begin
      if (load) begin
        x_q[l]    <= GAIN_W;
        y_q[l]    <= '0;
        z_q[l]    <= red[l].z;
        flip_q[l] <= red[l].flip;
      end else if (state_q == ST_ROT) begin
        z_q[l] <= zn[l];
        // quadrant fold undone after the last rotation
        if (rot_last && flip_q[l]) begin
          x_q[l] <= -xn[l];
          y_q[l] <= -yn[l];
        end else begin
          x_q[l] <= xn[l];
          y_q[l] <= yn[l];
        end
      end
    end
    if (state_q == ST_MUL) begin
      p_q[k_q] <= prod;
    end
  end

endmodule

[sv/cstr_fifo.sv]
// cstr_fifo: short queue of rotation matrices between the front and the back
// depends on cstr_pkg

module cstr_fifo import cstr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mat_t       push_mat_i,
  input  logic       pop_i,
  output mat_t       head_mat_o,
  output fifo_stat_t stat_o
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  mat_t          mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == CW'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_mat_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_mat_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full || pop_i)
    else $error("matrix queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("matrix queue read while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(FIFO_DEPTH))
    else $error("matrix queue count out of range");
`endif

endmodule

[sv/cstr_back.sv]
// cstr_back: walks 21 voigt components of a matrix, one four-factor product a cycle unless
// stalled, via three chained multipliers, weights, coef products and saturation; cstr_pkg

module cstr_back import cstr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fifo_stat_t           fifo_stat_i,
  input  mat_t                 head_mat_i,
  output logic                 pop_o,
  input  coef_t                coef_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           voigt_row_o,
  output logic [2:0]           voigt_col_o,
  output logic signed [VW-1:0] stiffness_value_o,
  output logic                 last_of_grain_o
);

  localparam int TW = 2 * KW + 2;
  localparam logic signed [SW-1:0] W_LIM   = SW'(2**30);
  localparam logic signed [TW-1:0] OUT_RND = TW'(2**27);
  localparam logic signed [TW-1:0] V_MAX   = TW'(64'sd549755813887);
  localparam logic signed [TW-1:0] V_MIN   = -V_MAX - TW'(1);
  localparam logic [2:0]           IDX_MAX = 3'd5;

  typedef struct packed {
    cls_e       cls;
    logic       first;
    logic       lastt;
    logic [2:0] a;
    logic [2:0] b;
  } tag_t;

  function automatic logic signed [WW-1:0] pick(input mat_t m, input logic [1:0] r,
                                                 input logic [1:0] c);
    logic [3:0] idx;
    idx = 4'({2'b00, r} * 4'd3 + {2'b00, c});
    if (idx < 4'd9) begin
      return m[idx];
    end
    return '0;
  endfunction

  function automatic logic signed [KW-1:0] to_weight(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    r = (s + SW'(2)) >>> 2;
    if (r > W_LIM) begin
      r = W_LIM;
    end else if (r < -W_LIM) begin
      r = -W_LIM;
    end
    return r[KW-1:0];
  endfunction

  logic       busy_q;
  logic [2:0] a_q, b_q;
  logic [4:0] t_q;
  mat_t       mat_q;

  logic                 s1_vld_q, s2_vld_q, s3_vld_q, w_vld_q, k_vld_q, out_vld_q;
  logic signed [WW-1:0] s1_m_q, s1_c_q, s1_d_q, s2_m_q, s2_d_q, s3_m_q;
  tag_t                 s1_tag_q, s2_tag_q, s3_tag_q;
  logic signed [SW-1:0] acc11_q, acc12_q, acc44_q;
  logic signed [SW-1:0] acc11_d, acc12_d, acc44_d;
  logic signed [KW-1:0] w11_q, w12_q, w44_q;
  logic [2:0]           w_a_q, w_b_q, k_a_q, k_b_q;
  logic signed [2*KW-1:0] k11_q, k12_q, k44_q;
  logic [2:0]           out_row_q, out_col_q;
  logic signed [VW-1:0] out_val_q;
  logic                 out_last_q;

  logic adv, start, issue;
  term_t term;
  logic signed [WW-1:0] opa, opb, opc, opd;
  logic signed [SW-1:0] m3e;
  logic signed [TW-1:0] total, sh;
  logic signed [VW-1:0] val;

  // the whole back pipeline holds while a finished result waits
  assign adv   = !out_vld_q || !out_stall_i;
  assign start = !busy_q && !fifo_stat_i.empty && adv;
  assign issue = busy_q && adv;
  assign pop_o = start;

  assign term = term_of(t_q);
  assign opa  = pick(mat_q, voigt_a(a_q), term.c0);
  assign opb  = pick(mat_q, voigt_b(a_q), term.c1);
  assign opc  = pick(mat_q, voigt_a(b_q), term.c2);
  assign opd  = pick(mat_q, voigt_b(b_q), term.c3);

  always_comb begin
    m3e     = SW'(s3_m_q);
    acc11_d = s3_tag_q.first ? '0 : acc11_q;
    acc12_d = s3_tag_q.first ? '0 : acc12_q;
    acc44_d = s3_tag_q.first ? '0 : acc44_q;
    case (s3_tag_q.cls)
      CLS_11:  acc11_d = acc11_d + m3e;
      CLS_12:  acc12_d = acc12_d + m3e;
      CLS_44:  acc44_d = acc44_d + m3e;
      default: acc44_d = acc44_d;
    endcase
  end

  always_comb begin
    total = TW'(k11_q) + TW'(k12_q) + TW'(k44_q) + OUT_RND;
    sh    = total >>> 28;
    if (sh > V_MAX) begin
      val = V_MAX[VW-1:0];
    end else if (sh < V_MIN) begin
      val = V_MIN[VW-1:0];
    end else begin
      val = sh[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      a_q       <= '0;
      b_q       <= '0;
      t_q       <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      w_vld_q   <= 1'b0;
      k_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (start) begin
        busy_q <= 1'b1;
        a_q    <= '0;
        b_q    <= '0;
        t_q    <= '0;
      end else if (issue) begin
        if (t_q == LAST_T) begin
          t_q <= '0;
          if (b_q == IDX_MAX) begin
            if (a_q == IDX_MAX) begin
              busy_q <= 1'b0;
            end else begin
              a_q <= a_q + 3'd1;
              b_q <= a_q + 3'd1;
            end
          end else begin
            b_q <= b_q + 3'd1;
          end
        end else begin
          t_q <= t_q + 5'd1;
        end
      end
      if (adv) begin
        s1_vld_q  <= issue;
        s2_vld_q  <= s1_vld_q;
        s3_vld_q  <= s2_vld_q;
        w_vld_q   <= s3_vld_q && s3_tag_q.lastt;
        k_vld_q   <= w_vld_q;
        out_vld_q <= k_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      mat_q <= head_mat_i;
    end
    if (adv) begin
      s1_m_q   <= mulw(opa, opb);
      s1_c_q   <= opc;
      s1_d_q   <= opd;
      s1_tag_q <= '{cls: term.cls, first: (t_q == '0), lastt: (t_q == LAST_T),
                    a: a_q, b: b_q};
      s2_m_q   <= mulw(s1_m_q, s1_c_q);
      s2_d_q   <= s1_d_q;
      s2_tag_q <= s1_tag_q;
      s3_m_q   <= mulw(s2_m_q, s2_d_q);
      s3_tag_q <= s2_tag_q;
      if (s3_vld_q) begin
        acc11_q <= acc11_d;
        acc12_q <= acc12_d;
        acc44_q <= acc44_d;
      end
      w11_q      <= to_weight(acc11_d);
      w12_q      <= to_weight(acc12_d);
      w44_q      <= to_weight(acc44_d);
      w_a_q      <= s3_tag_q.a;
      w_b_q      <= s3_tag_q.b;
      k11_q      <= w11_q * coef_i.k11;
      k12_q      <= w12_q * coef_i.k12;
      k44_q      <= w44_q * coef_i.k44;
      k_a_q      <= w_a_q;
      k_b_q      <= w_b_q;
      out_row_q  <= k_a_q;
      out_col_q  <= k_b_q;
      out_val_q  <= val;
      out_last_q <= (k_a_q == IDX_MAX);
    end
  end

  assign out_valid_o       = out_vld_q;
  assign voigt_row_o       = out_row_q;
  assign voigt_col_o       = out_col_q;
  assign stiffness_value_o = out_val_q;
  assign last_of_grain_o   = out_last_q;

`ifndef SYNTHESIS
  a_upper_triangle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_col_q >= out_row_q && out_col_q <= IDX_MAX)
    else $error("voigt index pair outside the upper triangle");
  a_last_is_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_last_q |-> out_row_q == IDX_MAX && out_col_q == IDX_MAX)
    else $error("last of grain flagged on a component other than 66");
  a_last_term_shear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q && s3_tag_q.lastt |-> s3_tag_q.cls == CLS_44)
    else $error("component closed on a term that is not a shear term");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy_q && a_q == '0 && b_q == '0 && t_q == '0)
    else $error("grain start did not reset the component walk");
`endif

endmodule

[sv/cubic_stiffness_tensor_rotation_core.sv]
// cubic_stiffness_tensor_rotation_core: top level, coefficient registers and the
// front / queue / back split; depends on cstr_pkg, cstr_front, cstr_fifo, cstr_back
//
//   channel  direction  handshake                 payload
//   in       into core  in_valid_i / in_stall_o   angle_first_i, angle_second_i, angle_third_i
//   out      from core  out_valid_o / out_stall_i voigt_row_o, voigt_col_o,
//                                                 stiffness_value_o, last_of_grain_o
//   cfg      into core  cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// front: per grain, the cordic iterations, then 14 products on one multiplier; it works
//   ahead of the back through a two-matrix queue
// back: per grain, a term walk of one four-factor product a cycle while out_stall_i
//   does not hold it (21 components of 21 terms, after a matrix load); after the walk of
//   the first component, its result still passes the s1, s2, s3, w, k and out registers
// reset clears the control state and the three coefficients to zero
// out_stall_i freezes the back pipeline; in_stall_o is high while the input slot holds
//   a set of angles the front has not yet taken

module cubic_stiffness_tensor_rotation_core import cstr_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [ANG_W-1:0] angle_first_i,
  input  logic signed [ANG_W-1:0] angle_second_i,
  input  logic signed [ANG_W-1:0] angle_third_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              voigt_row_o,
  output logic [2:0]              voigt_col_o,
  output logic signed [VW-1:0]    stiffness_value_o,
  output logic                    last_of_grain_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [KW-1:0]           cfg_data_i
);

  coef_t      coef_q;
  logic       push, pop;
  mat_t       push_mat, head_mat;
  fifo_stat_t fifo_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_C11: coef_q.k11 <= cfg_data_i;
        REG_C12: coef_q.k12 <= cfg_data_i;
        REG_C44: coef_q.k44 <= cfg_data_i;
        default: coef_q <= coef_q;
      endcase
    end
  end

  cstr_front #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .angle_first_i (angle_first_i),
    .angle_second_i(angle_second_i),
    .angle_third_i (angle_third_i),
    .push_o        (push),
    .push_mat_o    (push_mat),
    .fifo_stat_i   (fifo_stat)
  );

  cstr_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_mat_i(push_mat),
    .pop_i     (pop),
    .head_mat_o(head_mat),
    .stat_o    (fifo_stat)
  );

  cstr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fifo_stat_i      (fifo_stat),
    .head_mat_i       (head_mat),
    .pop_o            (pop),
    .coef_i           (coef_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .voigt_row_o      (voigt_row_o),
    .voigt_col_o      (voigt_col_o),
    .stiffness_value_o(stiffness_value_o),
    .last_of_grain_o  (last_of_grain_o)
  );

endmodule
